FILE: rtl/assert_macros.svh
// Assertion macros shared by the scaler RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/cnsd_pkg.sv
// Shared constants, register codes and types for the centred RGB565 scaler.
// No dependencies; imported by every module of the block but cnsd_ram.
package cnsd_pkg;

  localparam int unsigned MAX_SIDE    = 96;
  localparam int unsigned SIDE_W      = 7;
  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned Q8_W        = 9;
  localparam int unsigned Q8_ONE      = 256;
  localparam int unsigned SCALE_MIN   = 26;
  localparam int unsigned CFG_IDX_W   = 2;
  // reciprocal of the drawn side: ceil(2^RECIP_SHIFT / d), exact for u*s < 9216
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;
  localparam int unsigned DIV_CNT_W   = $clog2(RECIP_W);
  localparam int unsigned PROD_W      = ADDR_W + RECIP_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_SIDE,
    CFG_IMAGE_SIDE,
    CFG_SCALE,
    CFG_BRIGHTNESS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } setup_state_t;

  // geometry derived from the configuration registers
  typedef struct packed {
    logic              busy;
    logic [SIDE_W-1:0] c;
    logic [SIDE_W-1:0] s;
    logic [SIDE_W-1:0] d;
    logic [SIDE_W-1:0] off;
    logic [RECIP_W-1:0] recip;
    logic [Q8_W-1:0]   bq;
  } geom_t;

  // store access request leaving the mapping pipeline
  typedef struct packed {
    logic               is_read;
    logic               wr_ok;
    logic               drawn;
    logic               cerr;
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  addr;
  } mem_req_t;

endpackage

FILE: rtl/cnsd_ram.sv
// Generic single-port RAM with registered read, enable gated.
// No dependencies.
module cnsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wr_data;
      end
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/cnsd_setup.sv
// Configuration registers and derived geometry: drawn side, offset and a
// reciprocal of the drawn side from a bit-serial divider. Uses cnsd_pkg.
`include "assert_macros.svh"

module cnsd_setup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cnsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnsd_pkg::Q8_W-1:0]       cfg_data,
  output cnsd_pkg::geom_t                 geom
);
  import cnsd_pkg::*;

  logic [SIDE_W-1:0]    canvas_side_r, image_side_r;
  logic [Q8_W-1:0]      scale_r, bright_r;
  setup_state_t         state_r, state_nxt;
  logic [SIDE_W-1:0]    c_r, s_r, d_r, off_r, rem_r;
  logic [Q8_W-1:0]      bq_r;
  logic [RECIP_W-1:0]   quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [SIDE_W-1:0]    c_sat, s_sat, d_lim;
  logic [Q8_W-1:0]      sc_sat, bq_sat;
  logic [15:0]          scale_prod;
  logic [7:0]           d_raw;
  logic [SIDE_W:0]      trial;
  logic                 ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_side_r <= SIDE_W'(MAX_SIDE);
      image_side_r  <= SIDE_W'(MAX_SIDE);
      scale_r       <= Q8_W'(Q8_ONE);
      bright_r      <= Q8_W'(Q8_ONE);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CANVAS_SIDE: canvas_side_r <= cfg_data[SIDE_W-1:0];
        CFG_IMAGE_SIDE:  image_side_r  <= cfg_data[SIDE_W-1:0];
        CFG_SCALE:       scale_r       <= cfg_data;
        CFG_BRIGHTNESS:  bright_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the registers to their meaningful ranges
  always_comb begin
    c_sat  = (canvas_side_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : canvas_side_r;
    s_sat  = (image_side_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) :
             ((image_side_r == '0) ? SIDE_W'(1) : image_side_r);
    sc_sat = (scale_r < Q8_W'(SCALE_MIN)) ? Q8_W'(SCALE_MIN) :
             ((scale_r > Q8_W'(Q8_ONE)) ? Q8_W'(Q8_ONE) : scale_r);
    bq_sat = (bright_r > Q8_W'(Q8_ONE)) ? Q8_W'(Q8_ONE) : bright_r;
    scale_prod = 16'(c_sat) * 16'(sc_sat);
    d_raw = scale_prod[15:8];
    if (d_raw == '0) begin
      d_lim = SIDE_W'(1);
    end else begin
      d_lim = d_raw[SIDE_W-1:0];
    end
    if (d_lim > c_sat) begin
      d_lim = c_sat;
    end
  end

  // restoring divider step, one quotient bit per cycle
  assign trial = {rem_r, quo_r[RECIP_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SCALE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (cnt_r == DIV_CNT_W'(RECIP_W - 1)) ? ST_DONE : ST_DIV;
      ST_DONE:  state_nxt = ST_DONE;
      default:  state_nxt = ST_SCALE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SCALE: begin
        c_r   <= c_sat;
        s_r   <= s_sat;
        bq_r  <= bq_sat;
        d_r   <= d_lim;
        off_r <= SIDE_W'((c_sat - d_lim) >> 1);
        // dividend 2^21 + d - 1 gives the rounded-up quotient
        quo_r <= RECIP_W'(RECIP_ONE) + RECIP_W'(d_lim) - RECIP_W'(1);
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? SIDE_W'(trial - {1'b0, d_r}) : trial[SIDE_W-1:0];
        quo_r <= {quo_r[RECIP_W-2:0], ge};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    geom.busy  = (state_r != ST_DONE);
    geom.c     = c_r;
    geom.s     = s_r;
    geom.d     = d_r;
    geom.off   = off_r;
    geom.recip = quo_r;
    geom.bq    = bq_r;
  end

  `ASSERT_CLK(a_recip_ceil, clk, rst_n, (state_r == ST_DONE && d_r != '0) |-> ((32'(quo_r) * 32'(d_r) >= 32'(RECIP_ONE)) && (32'(quo_r) * 32'(d_r) < 32'(RECIP_ONE) + 32'(d_r))), "reciprocal of drawn side is not rounded up")
  `ASSERT_CLK(a_cfg_restarts, clk, rst_n, cfg_we |=> geom.busy, "config write did not restart setup")

endmodule

FILE: rtl/cnsd_map.sv
// Four-stage coordinate mapping: canvas bounds, offset removal, scaling by
// the image side and by the drawn-side reciprocal, store index. Uses cnsd_pkg.
`include "assert_macros.svh"

module cnsd_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [cnsd_pkg::ADDR_W-1:0]   in_source_address,
  input  logic [cnsd_pkg::COLOR_W-1:0]  in_source_color,
  input  logic [cnsd_pkg::SIDE_W-1:0]   in_canvas_x,
  input  logic [cnsd_pkg::SIDE_W-1:0]   in_canvas_y,
  input  cnsd_pkg::geom_t               geom,
  output logic                          req_valid,
  output cnsd_pkg::mem_req_t            req,
  input  logic                          req_ready
);
  import cnsd_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic load1, load2, load3, load4;
  mem_req_t it1_r, it2_r, it3_r, it4_r, it1_nxt, it4_nxt;
  logic [SIDE_W-1:0] u1_r, w1_r, u_nxt, w_nxt;
  logic [ADDR_W-1:0] nx2_r, ny2_r;
  logic [SIDE_W-1:0] qx3_r, qy3_r;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic              x_in, y_in, cerr;

  assign load4    = !v4_r || req_ready;
  assign load3    = !v3_r || load4;
  assign load2    = !v2_r || load3;
  assign load1    = !v1_r || load2;
  assign in_ready = load1;

  // stage 1: bounds and offset
  always_comb begin
    u_nxt = in_canvas_x - geom.off;
    w_nxt = in_canvas_y - geom.off;
    cerr  = (in_canvas_x >= geom.c) || (in_canvas_y >= geom.c);
    x_in  = (in_canvas_x >= geom.off) && (u_nxt < geom.d);
    y_in  = (in_canvas_y >= geom.off) && (w_nxt < geom.d);
    it1_nxt.is_read = (in_opcode == OP_READ);
    it1_nxt.wr_ok   = (in_source_address < ADDR_W'(STORE_DEPTH));
    it1_nxt.drawn   = !cerr && x_in && y_in;
    it1_nxt.cerr    = cerr;
    it1_nxt.color   = in_source_color;
    it1_nxt.addr    = in_source_address;
  end

  // stage 3: floor(n / d) as (n * ceil(2^21 / d)) >> 21
  assign prod_x = PROD_W'(nx2_r) * PROD_W'(geom.recip);
  assign prod_y = PROD_W'(ny2_r) * PROD_W'(geom.recip);

  always_comb begin
    it4_nxt = it3_r;
    if (it3_r.is_read) begin
      it4_nxt.addr = ADDR_W'(qy3_r) * ADDR_W'(geom.s) + ADDR_W'(qx3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (load1) v1_r <= in_valid;
      if (load2) v2_r <= v1_r;
      if (load3) v3_r <= v2_r;
      if (load4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      it1_r <= it1_nxt;
      u1_r  <= u_nxt;
      w1_r  <= w_nxt;
    end
    if (load2) begin
      it2_r <= it1_r;
      nx2_r <= ADDR_W'(u1_r) * ADDR_W'(geom.s);
      ny2_r <= ADDR_W'(w1_r) * ADDR_W'(geom.s);
    end
    if (load3) begin
      it3_r <= it2_r;
      qx3_r <= prod_x[RECIP_SHIFT +: SIDE_W];
      qy3_r <= prod_y[RECIP_SHIFT +: SIDE_W];
    end
    if (load4) begin
      it4_r <= it4_nxt;
    end
  end

  assign req_valid = v4_r;
  assign req       = it4_r;

  `ASSERT_CLK(a_idx_in_store, clk, rst_n, (req_valid && req.is_read && req.drawn) |-> (req.addr < ADDR_W'(STORE_DEPTH)), "mapped source index beyond the store")

endmodule

FILE: rtl/centered_nearest_scale_rgb565_dim.sv
// Centred nearest-neighbour RGB565 scaler with dimming. A write transaction
// (opcode 0) stores one source pixel; a read transaction (opcode 1) presents one
// canvas pixel through six register stages, and one transaction is taken every
// cycle while the output is drained. The mapping runs through four register
// stages, the single-port image store takes one access per cycle while the
// output is drained, and a final stage dims the three channels. After reset and
// after every configuration write, in_ready stays low while the drawn side,
// offset and the reciprocal of the drawn side are worked out (one setup step,
// then a bit-serial divide). Pixels never written read as undefined.
// Depends on cnsd_pkg, cnsd_setup, cnsd_map and cnsd_ram.
`include "assert_macros.svh"

module centered_nearest_scale_rgb565_dim (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cnsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnsd_pkg::Q8_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [cnsd_pkg::ADDR_W-1:0]   in_source_address,
  input  logic [cnsd_pkg::COLOR_W-1:0]  in_source_color,
  input  logic [cnsd_pkg::SIDE_W-1:0]   in_canvas_x,
  input  logic [cnsd_pkg::SIDE_W-1:0]   in_canvas_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cnsd_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_inside_drawn,
  output logic                          out_coord_error
);
  import cnsd_pkg::*;

  geom_t              geom;
  logic               map_ready, req_valid;
  mem_req_t           req;
  logic               load5, load6, ram_we;
  logic [COLOR_W-1:0] rd_data;
  logic               v5_r, rd5_r, inside5_r, cerr5_r;
  logic               out_valid_r, out_inside_r, out_cerr_r;
  logic [COLOR_W-1:0] out_pixel_r, pixel_nxt;
  logic [13:0]        r_prod, g_prod, b_prod;

  cnsd_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  cnsd_map u_map (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid && !geom.busy),
    .in_ready          (map_ready),
    .in_opcode         (in_opcode),
    .in_source_address (in_source_address),
    .in_source_color   (in_source_color),
    .in_canvas_x       (in_canvas_x),
    .in_canvas_y       (in_canvas_y),
    .geom              (geom),
    .req_valid         (req_valid),
    .req               (req),
    .req_ready         (load5)
  );

  assign in_ready = map_ready && !geom.busy;

  // stage 5 is the store access; writes end there
  assign load6  = !out_valid_r || out_ready;
  assign load5  = !v5_r || !rd5_r || load6;
  assign ram_we = load5 && req_valid && !req.is_read && req.wr_ok;

  cnsd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .en      (load5),
    .we      (ram_we),
    .addr    (req.addr),
    .wr_data (req.color),
    .rd_data (rd_data)
  );

  // stage 6: dim each channel, truncating
  always_comb begin
    r_prod = 14'(rd_data[15:11]) * 14'(geom.bq);
    g_prod = 14'(rd_data[10:5]) * 14'(geom.bq);
    b_prod = 14'(rd_data[4:0]) * 14'(geom.bq);
    pixel_nxt = inside5_r ? {r_prod[12:8], g_prod[13:8], b_prod[12:8]} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load5) v5_r <= req_valid;
      if (load6) out_valid_r <= v5_r && rd5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      rd5_r     <= req.is_read;
      inside5_r <= req.drawn;
      cerr5_r   <= req.cerr;
    end
    if (load6) begin
      out_pixel_r  <= pixel_nxt;
      out_inside_r <= inside5_r;
      out_cerr_r   <= cerr5_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_color  = out_pixel_r;
  assign out_inside_drawn = out_inside_r;
  assign out_coord_error  = out_cerr_r;

  `ASSERT_NEVER(a_inside_no_err, clk, rst_n, out_valid && out_inside_drawn && out_coord_error, "pixel flagged both drawn and beyond the canvas")
  `ASSERT_CLK(a_black_outside, clk, rst_n, (out_valid && !out_inside_drawn) |-> (out_pixel_color == '0), "non-zero pixel outside the drawn square")
  `ASSERT_CLK(a_cfg_blocks_input, clk, rst_n, cfg_we |=> !in_ready, "input taken right after a config write")

endmodule
